[design/plb_pkg.sv]
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants for the posting list builder
// Field widths of the request and response beats, the command codes that the
// block uses, and the status codes that the block and its checker both use.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

   localparam int ID_BITS       = 32;
   localparam int TERM_BITS     = 16;
   localparam int DOC_FREQ_BITS = 11;

   typedef logic [ID_BITS-1:0]       doc_id_type;
   typedef logic [TERM_BITS-1:0]     term_count_type;
   typedef logic [DOC_FREQ_BITS-1:0] doc_freq_type;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

[design/plb_table.sv]
// ----------------------------------------------------------------------------
// plb_table: posting list entry storage
// Two arrays (document id and occurrence count) sharing one write port and
// one registered read port. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_table
   import plb_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int COUNT_BITS = 16,
   parameter int AW         = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire doc_id_type            wr_id,
   input  wire logic [COUNT_BITS-1:0] wr_count,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output      doc_id_type            rd_id,
   output      logic [COUNT_BITS-1:0] rd_count
);

   doc_id_type            id_mem [DEPTH];
   logic [COUNT_BITS-1:0] count_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]    <= wr_id;
         count_mem[wr_addr] <= wr_count;
      end
   end

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id    <= id_mem[rd_addr];
         rd_count <= count_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[design/posting_list_builder.sv]
// An add goes through a read state and then a write state, which registers its
//   result beat once the result slot is free; the next request is taken in idle.
// A query visits k entries, each with a read state and then a compare state,
//   and registers its result beat once the result slot is free.
// Throughput is set by the single table read port and the one shared comparator.
// Synchronous reset empties the list and the result slot; the table itself is
//   not swept, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
// posting_list_builder: single-term posting list with add and query
// Keeps (document id, count) entries in fill order. Adds bump the last entry,
// append a new one or are dropped when full; queries walk entries in fill order.
// ----------------------------------------------------------------------------
`default_nettype none

module posting_list_builder
   import plb_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   // Request channel
   input  wire logic           req_valid,
   output      logic           req_stall,
   input  wire logic           req_cmd,
   input  wire doc_id_type     req_doc_id,
   // Response channel
   output      logic           rsp_valid,
   input  wire logic           rsp_stall,
   output      term_count_type rsp_term_count,
   output      doc_freq_type   rsp_doc_freq,
   output      logic           rsp_status
);

   // Address width indexes the table; the fill count must also hold MAX_ENTRIES.
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int UW = $clog2(MAX_ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD_RD = 3'd1;
   localparam logic [2:0] S_ADD_WR = 3'd2;
   localparam logic [2:0] S_Q_RD   = 3'd3;
   localparam logic [2:0] S_Q_CMP  = 3'd4;

   logic [2:0]     state_ff, state_in;
   doc_id_type     doc_ff, doc_in;
   logic [UW-1:0]  idx_ff, idx_in;
   logic [UW-1:0]  used_ff, used_in;

   logic           rsp_valid_ff, rsp_valid_in;
   term_count_type rsp_term_ff, rsp_term_in;
   doc_freq_type   rsp_freq_ff, rsp_freq_in;
   logic           rsp_status_ff, rsp_status_in;

   // Table port signals.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [COUNT_BITS-1:0] wr_count;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   doc_id_type            rd_id;
   logic [COUNT_BITS-1:0] rd_count;

   logic [AW-1:0] last_idx;
   logic          out_free;
   logic          req_take;
   logic          done;

   assign last_idx = AW'(used_ff - UW'(1));
   // The result slot can take a new beat when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   plb_table #(
      .DEPTH      (MAX_ENTRIES),
      .COUNT_BITS (COUNT_BITS),
      .AW         (AW)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_id    (doc_ff),
      .wr_count (wr_count),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_id    (rd_id),
      .rd_count (rd_count)
   );

   // The sequencer shares one read port and one id comparator between the
   // add path (read-compare-write of the last entry) and the query walk.
   always_comb begin
      state_in      = state_ff;
      doc_in        = doc_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      wr_en         = 1'b0;
      wr_addr       = last_idx;
      wr_count      = COUNT_BITS'(1);
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      done          = 1'b0;
      rsp_term_in   = rsp_term_ff;
      rsp_status_in = STATUS_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               doc_in = req_doc_id;
               idx_in = '0;
               if (req_cmd == CMD_QUERY) begin
                  state_in = S_Q_RD;
               end else begin
                  state_in = S_ADD_RD;
               end
            end
         end

         S_ADD_RD: begin
            // An empty list has no last entry to fetch.
            rd_en    = (used_ff != '0);
            rd_addr  = last_idx;
            state_in = S_ADD_WR;
         end

         S_ADD_WR: begin
            if (out_free) begin
               done        = 1'b1;
               state_in    = S_IDLE;
               rsp_term_in = '0;
               if (used_ff != '0 && rd_id == doc_ff) begin
                  // Same document as the last entry: bump its count, saturating.
                  if (rd_count != COUNT_MAX) begin
                     wr_en    = 1'b1;
                     wr_addr  = last_idx;
                     wr_count = rd_count + COUNT_BITS'(1);
                  end
               end else if (used_ff == UW'(MAX_ENTRIES)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = used_ff[AW-1:0];
                  wr_count = COUNT_BITS'(1);
                  used_in  = used_ff + UW'(1);
               end
            end
         end

         S_Q_RD: begin
            if (idx_ff < used_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[AW-1:0];
               state_in = S_Q_CMP;
            end else if (out_free) begin
               // Ran off the end of the list without a match.
               done        = 1'b1;
               state_in    = S_IDLE;
               rsp_term_in = '0;
            end
         end

         S_Q_CMP: begin
            if (rd_id == doc_ff) begin
               if (out_free) begin
                  done        = 1'b1;
                  state_in    = S_IDLE;
                  rsp_term_in = TERM_BITS'(rd_count);
               end
            end else if (rd_id > doc_ff) begin
               // Ids must be added in ascending order (not enforced); stop here.
               if (out_free) begin
                  done        = 1'b1;
                  state_in    = S_IDLE;
                  rsp_term_in = '0;
               end
            end else begin
               idx_in   = idx_ff + UW'(1);
               state_in = S_Q_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_freq_in = done ? DOC_FREQ_BITS'(used_in) : rsp_freq_ff;
      if (!done) begin
         rsp_status_in = rsp_status_ff;
      end
      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      doc_ff        <= doc_in;
      idx_ff        <= idx_in;
      rsp_term_ff   <= rsp_term_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term_count = rsp_term_ff;
   assign rsp_doc_freq   = rsp_freq_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

[design/plb_checker.sv]
// ----------------------------------------------------------------------------
// plb_checker: port-level checks for the posting list builder
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_checker
   import plb_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
) (
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_valid,
   input wire logic           req_stall,
   input wire logic           rsp_valid,
   input wire logic           rsp_stall,
   input wire term_count_type rsp_term_count,
   input wire doc_freq_type   rsp_doc_freq,
   input wire logic           rsp_status
);

   // A stalled response beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_term_count) &&
      $stable(rsp_doc_freq) && $stable(rsp_status))
      else $error("response beat changed while stalled");

   // Reset leaves no response pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one still in work");

   // A dropped add only happens with a full list and carries no count.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
      rsp_term_count == '0 && rsp_doc_freq == DOC_FREQ_BITS'(MAX_ENTRIES))
      else $error("full status with inconsistent fields");

endmodule

bind posting_list_builder plb_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_plb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_term_count (rsp_term_count),
   .rsp_doc_freq   (rsp_doc_freq),
   .rsp_status     (rsp_status)
);

`default_nettype wire
